// ----- rtl/trcs_pkg.sv -----
// shared types, codes and constants of the tftp read client sequencer
package trcs_pkg;

    // payload bytes in a full data block
    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned HEADER_BYTES = 4;

    localparam logic [15:0] SERVER_PORT_INIT = 16'd69;
    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SERVER_ADDRESS = 2'd0;
    localparam logic [1:0] REG_BUFFER_LIMIT = 2'd1;
    localparam logic [1:0] REG_CALLBACK_MODE = 2'd2;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd3;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_PACKET  = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_SEND_RRQ  = 3'd1,
        ACT_SEND_ACK  = 3'd2,
        ACT_FINAL_ACK = 3'd3,
        ACT_FAIL      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_DONE   = 2'd2,
        PH_FAILED = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic [9:0]  packet_length;
        logic [15:0] source_port;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] ack_block;
        logic [15:0] dest_port;
        logic [31:0] write_offset;
        logic [9:0]  write_count;
        logic [9:0]  deliver_length;
        logic        last_block;
        logic [31:0] total_size;
        logic [15:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic [31:0] server_address;
        logic [31:0] buffer_limit;
        logic        callback_mode;
        logic [7:0]  max_retries;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] expected_block;
        logic [7:0]  retry_count;
        logic        block_seen;
        logic [15:0] server_port;
        logic [31:0] byte_total;
    } seq_state_t;

endpackage

// ----- rtl/tftp_read_client_sequencer.sv -----
// top level of the tftp read client sequencer
//
// Receive-side control of a TFTP read. Each input beat is one event: start,
// received packet header, or receive timeout. Each event yields exactly one
// output beat with the action to take (request, ack, final ack, fail or none)
// plus the buffer write window or callback length and the running byte total.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// and must only change while no event is in flight.
// An accepted event waits in the input register; its result is computed from
// it and held in the output register. Throughput is one event per cycle while
// the receiver does not stall; the state update itself is combinational.
// When the receiver stalls, the output beat holds and one more event can wait
// in the input register; after that the input side stalls.
// Reset clears the sequencer to idle, expected block 1, server port 69 and a
// zero byte total, and loads the register defaults.
module tftp_read_client_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  trcs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output trcs_pkg::out_item_t out_data
);

    trcs_pkg::cfg_t       cfg;
    trcs_pkg::seq_state_t state_reg;
    trcs_pkg::seq_state_t state_next;
    trcs_pkg::out_item_t  step_res;
    trcs_pkg::in_item_t   in_item_reg;
    logic                 in_vld_reg;
    logic                 in_vld_next;
    trcs_pkg::out_item_t  out_item_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 out_free;
    logic                 fire;
    logic                 in_take;

    trcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trcs_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // handshake control
    assign out_free = !out_vld_reg || !out_stall;
    assign fire = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
        if (fire)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // control registers and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg.phase <= trcs_pkg::PH_IDLE;
            state_reg.expected_block <= 16'd1;
            state_reg.retry_count <= 8'd0;
            state_reg.block_seen <= 1'b0;
            state_reg.server_port <= trcs_pkg::SERVER_PORT_INIT;
            state_reg.byte_total <= 32'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_data;
        if (fire)
            out_item_reg <= step_res;
    end

    assign out_valid = out_vld_reg;
    assign out_data = out_item_reg;

endmodule

// ----- rtl/trcs_cfg.sv -----
// configuration register file of the tftp read client sequencer
module trcs_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output trcs_pkg::cfg_t cfg
);

    trcs_pkg::cfg_t cfg_reg;
    trcs_pkg::cfg_t cfg_next;

    // decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                trcs_pkg::REG_SERVER_ADDRESS: cfg_next.server_address = cfg_data;
                trcs_pkg::REG_BUFFER_LIMIT:   cfg_next.buffer_limit = cfg_data;
                trcs_pkg::REG_CALLBACK_MODE:  cfg_next.callback_mode = cfg_data[0];
                trcs_pkg::REG_MAX_RETRIES:    cfg_next.max_retries = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.server_address <= 32'd0;
            cfg_reg.buffer_limit <= 32'hFFFF_FFFF;
            cfg_reg.callback_mode <= 1'b0;
            cfg_reg.max_retries <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/trcs_step.sv -----
// next state and result for one event of the tftp read client sequencer
module trcs_step (
    input  trcs_pkg::cfg_t       cfg,
    input  trcs_pkg::seq_state_t cur,
    input  trcs_pkg::in_item_t   item,
    output trcs_pkg::seq_state_t nxt,
    output trcs_pkg::out_item_t  res
);

    localparam logic [9:0] BLOCK_LEN = 10'(trcs_pkg::BLOCK_BYTES);
    localparam logic [9:0] HEADER_LEN = 10'(trcs_pkg::HEADER_BYTES);

    logic [9:0]  raw_len;
    logic [9:0]  data_len;
    logic        is_last;
    logic [31:0] data_len_w;
    logic [31:0] room;
    logic        has_room;
    logic [9:0]  clip_cnt;
    logic [32:0] sum;
    logic [31:0] sat_total;
    logic        start_bad;
    logic        is_active;

    // payload length, clipped to one block, and buffer window arithmetic
    always_comb
    begin
        raw_len = item.packet_length - HEADER_LEN;
        data_len = (raw_len > BLOCK_LEN) ? BLOCK_LEN : raw_len;
        is_last = data_len < BLOCK_LEN;
        data_len_w = {22'd0, data_len};
        has_room = cur.byte_total < cfg.buffer_limit;
        room = cfg.buffer_limit - cur.byte_total;
        clip_cnt = (data_len_w < room) ? data_len : room[9:0];
        sum = {1'b0, cur.byte_total} + {1'b0, data_len_w};
        sat_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        start_bad = (cfg.server_address == 32'd0)
                    || (!cfg.callback_mode && (cfg.buffer_limit == 32'd0));
        is_active = cur.phase == trcs_pkg::PH_ACTIVE;
    end

    // event decode
    always_comb
    begin
        nxt = cur;
        res = '0;
        case (trcs_pkg::mode_t'(item.mode))
            trcs_pkg::MODE_START:
            begin
                nxt.expected_block = 16'd1;
                nxt.retry_count = 8'd1;
                nxt.block_seen = 1'b0;
                nxt.server_port = trcs_pkg::SERVER_PORT_INIT;
                nxt.byte_total = 32'd0;
                if (start_bad)
                begin
                    nxt.phase = trcs_pkg::PH_FAILED;
                    res.action = trcs_pkg::ACT_FAIL;
                end
                else
                begin
                    nxt.phase = trcs_pkg::PH_ACTIVE;
                    res.action = trcs_pkg::ACT_SEND_RRQ;
                end
            end
            trcs_pkg::MODE_PACKET:
            begin
                if (is_active)
                begin
                    // server port is learned from every packet while active, even ignored ones
                    nxt.server_port = item.source_port;
                    if (item.packet_length < HEADER_LEN)
                    begin
                        res.action = trcs_pkg::ACT_NONE;
                    end
                    else if (item.packet_opcode == trcs_pkg::OP_ERROR)
                    begin
                        nxt.phase = trcs_pkg::PH_FAILED;
                        res.action = trcs_pkg::ACT_FAIL;
                        res.error_code = item.packet_block;
                    end
                    else if ((item.packet_opcode == trcs_pkg::OP_DATA)
                             && (item.packet_block == cur.expected_block))
                    begin
                        if (cfg.callback_mode)
                        begin
                            res.deliver_length = data_len;
                        end
                        else if (has_room)
                        begin
                            res.write_offset = cur.byte_total;
                            res.write_count = clip_cnt;
                        end
                        else
                        begin
                            res.write_offset = cfg.buffer_limit;
                        end
                        nxt.byte_total = sat_total;
                        res.ack_block = cur.expected_block;
                        if (is_last)
                        begin
                            nxt.phase = trcs_pkg::PH_DONE;
                            res.action = trcs_pkg::ACT_FINAL_ACK;
                            res.last_block = 1'b1;
                        end
                        else
                        begin
                            nxt.expected_block = cur.expected_block + 16'd1;
                            nxt.retry_count = 8'd1;
                            nxt.block_seen = 1'b1;
                            res.action = trcs_pkg::ACT_SEND_ACK;
                        end
                    end
                    else
                    begin
                        res.action = trcs_pkg::ACT_NONE;
                    end
                end
            end
            trcs_pkg::MODE_TIMEOUT:
            begin
                if (is_active)
                begin
                    if (cur.retry_count >= cfg.max_retries)
                    begin
                        nxt.phase = trcs_pkg::PH_FAILED;
                        res.action = trcs_pkg::ACT_FAIL;
                    end
                    else
                    begin
                        // resend the last message
                        nxt.retry_count = cur.retry_count + 8'd1;
                        if (cur.block_seen)
                        begin
                            res.action = trcs_pkg::ACT_SEND_ACK;
                            res.ack_block = cur.expected_block - 16'd1;
                        end
                        else
                        begin
                            res.action = trcs_pkg::ACT_SEND_RRQ;
                        end
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        res.dest_port = nxt.server_port;
        res.total_size = nxt.byte_total;
    end

endmodule

// ----- bench/tb_tftp_read_client_sequencer.sv -----
// self-checking testbench: random and directed events, replies checked against a predictor
`timescale 1ns / 1ps

module tb_tftp_read_client_sequencer;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [1:0]          cfg_index = trcs_pkg::REG_SERVER_ADDRESS;
    logic [31:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    trcs_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    trcs_pkg::out_item_t out_data;

    // predictor copy of the registers and the transfer state
    trcs_pkg::cfg_t       regs;
    trcs_pkg::seq_state_t seq;

    trcs_pkg::in_item_t  event_feed[$];
    trcs_pkg::out_item_t due_replies[$];
    trcs_pkg::out_item_t want;

    int         mismatches = 0;
    int         send_gap;
    int         stall_left;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    logic       long_hold_armed = 1'b0;
    logic       long_hold_done;

    tftp_read_client_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // predict the reply to one event and advance the transfer state
    function automatic trcs_pkg::out_item_t follow_event(trcs_pkg::in_item_t ev);
        trcs_pkg::out_item_t r;
        logic [31:0]         dlen;
        logic [31:0]         room;
        logic [31:0]         wcnt;
        r = '0;
        if (ev.mode == trcs_pkg::MODE_START)
        begin
            seq.expected_block = 16'd1;
            seq.retry_count = 8'd1;
            seq.block_seen = 1'b0;
            seq.server_port = trcs_pkg::SERVER_PORT_INIT;
            seq.byte_total = '0;
            if (regs.server_address == 32'd0
                || (!regs.callback_mode && regs.buffer_limit == 32'd0))
            begin
                seq.phase = trcs_pkg::PH_FAILED;
                r.action = trcs_pkg::ACT_FAIL;
            end
            else
            begin
                seq.phase = trcs_pkg::PH_ACTIVE;
                r.action = trcs_pkg::ACT_SEND_RRQ;
            end
        end
        else if (ev.mode == trcs_pkg::MODE_PACKET && seq.phase == trcs_pkg::PH_ACTIVE)
        begin
            // the port is learned even from packets that are then dropped
            seq.server_port = ev.source_port;
            if ({22'd0, ev.packet_length} < trcs_pkg::HEADER_BYTES)
            begin
                r.action = trcs_pkg::ACT_NONE;
            end
            else if (ev.packet_opcode == trcs_pkg::OP_ERROR)
            begin
                seq.phase = trcs_pkg::PH_FAILED;
                r.action = trcs_pkg::ACT_FAIL;
                r.error_code = ev.packet_block;
            end
            else if (ev.packet_opcode == trcs_pkg::OP_DATA
                     && ev.packet_block == seq.expected_block)
            begin
                dlen = {22'd0, ev.packet_length} - trcs_pkg::HEADER_BYTES;
                if (dlen > trcs_pkg::BLOCK_BYTES)
                    dlen = trcs_pkg::BLOCK_BYTES;
                r.last_block = (dlen < trcs_pkg::BLOCK_BYTES);
                // write window, clipped once the buffer is full
                if (regs.callback_mode)
                begin
                    r.deliver_length = dlen[9:0];
                end
                else if (seq.byte_total < regs.buffer_limit)
                begin
                    room = regs.buffer_limit - seq.byte_total;
                    wcnt = (dlen < room) ? dlen : room;
                    r.write_offset = seq.byte_total;
                    r.write_count = wcnt[9:0];
                end
                else
                begin
                    r.write_offset = regs.buffer_limit;
                end
                if (seq.byte_total > 32'hFFFF_FFFF - dlen)
                    seq.byte_total = 32'hFFFF_FFFF;
                else
                    seq.byte_total = seq.byte_total + dlen;
                r.ack_block = seq.expected_block;
                if (r.last_block)
                begin
                    seq.phase = trcs_pkg::PH_DONE;
                    r.action = trcs_pkg::ACT_FINAL_ACK;
                end
                else
                begin
                    seq.expected_block = seq.expected_block + 16'd1;
                    seq.retry_count = 8'd1;
                    seq.block_seen = 1'b1;
                    r.action = trcs_pkg::ACT_SEND_ACK;
                end
            end
        end
        else if (ev.mode == trcs_pkg::MODE_TIMEOUT && seq.phase == trcs_pkg::PH_ACTIVE)
        begin
            // resend the last message until the retry budget is spent
            if (seq.retry_count >= regs.max_retries)
            begin
                seq.phase = trcs_pkg::PH_FAILED;
                r.action = trcs_pkg::ACT_FAIL;
            end
            else
            begin
                seq.retry_count = seq.retry_count + 8'd1;
                if (!seq.block_seen)
                begin
                    r.action = trcs_pkg::ACT_SEND_RRQ;
                end
                else
                begin
                    r.action = trcs_pkg::ACT_SEND_ACK;
                    r.ack_block = seq.expected_block - 16'd1;
                end
            end
        end
        r.dest_port = seq.server_port;
        r.total_size = seq.byte_total;
        return r;
    endfunction

    function automatic trcs_pkg::in_item_t make_ev(logic [1:0] m, logic [15:0] op,
                                                   logic [15:0] blk, logic [9:0] len,
                                                   logic [15:0] port);
        trcs_pkg::in_item_t ev;
        ev.mode = m;
        ev.packet_opcode = op;
        ev.packet_block = blk;
        ev.packet_length = len;
        ev.source_port = port;
        return ev;
    endfunction

    // event of the given mode with random header fields
    function automatic trcs_pkg::in_item_t rand_ev(logic [1:0] m);
        return make_ev(m, 16'($urandom), 16'($urandom), 10'($urandom), 16'($urandom));
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    // event driver: one beat per handshake, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_replies.push_back(follow_event(in_data));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (event_feed.size() > 0)
                begin
                    in_data <= event_feed.pop_front();
                    in_valid <= 1'b1;
                    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // reply stall: random bursts plus one long hold-off while events keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (long_hold_armed && !long_hold_done && in_valid)
            begin
                long_hold_done = 1'b1;
                stall_left = 64;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // reply monitor: compare each beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_replies.size() == 0)
            begin
                $display("%0t: reply mismatch: expected none, got %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = due_replies.pop_front();
                check_field("action", 32'(want.action), 32'(out_data.action));
                check_field("ack_block", 32'(want.ack_block), 32'(out_data.ack_block));
                check_field("dest_port", 32'(want.dest_port), 32'(out_data.dest_port));
                check_field("write_offset", want.write_offset, out_data.write_offset);
                check_field("write_count", 32'(want.write_count),
                            32'(out_data.write_count));
                check_field("deliver_length", 32'(want.deliver_length),
                            32'(out_data.deliver_length));
                check_field("last_block", 32'(want.last_block), 32'(out_data.last_block));
                check_field("total_size", want.total_size, out_data.total_size);
                check_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
            end
        end
    end

    // wait until every event is taken and every reply has come back
    task automatic settle();
        do @(negedge clk);
        while (event_feed.size() != 0 || in_valid || due_replies.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            trcs_pkg::REG_SERVER_ADDRESS: regs.server_address = val;
            trcs_pkg::REG_BUFFER_LIMIT:   regs.buffer_limit = val;
            trcs_pkg::REG_CALLBACK_MODE:  regs.callback_mode = val[0];
            trcs_pkg::REG_MAX_RETRIES:    regs.max_retries = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] addr, logic [31:0] limit, logic cb,
                              logic [7:0] retries);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(trcs_pkg::REG_SERVER_ADDRESS, addr);
        write_reg(trcs_pkg::REG_BUFFER_LIMIT, limit);
        write_reg(trcs_pkg::REG_CALLBACK_MODE, {noise[31:1], cb});
        write_reg(trcs_pkg::REG_MAX_RETRIES, {noise[23:0], retries});
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // one read transfer with random content and occasional disturbances
    task automatic queue_transfer(int blocks);
        logic [15:0] port;
        logic [9:0]  len;
        int          b;
        int          ending;
        port = ($urandom_range(0, 3) == 0) ? trcs_pkg::SERVER_PORT_INIT : 16'($urandom);
        event_feed.push_back(rand_ev(trcs_pkg::MODE_START));
        for (b = 1; b <= blocks; b++)
        begin
            case ($urandom_range(0, 19))
                0: event_feed.push_back(rand_ev(trcs_pkg::MODE_TIMEOUT));
                1: event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA,
                                                16'(b - 1), 10'd516, port));
                2: event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, 16'($urandom),
                                                16'($urandom), 10'($urandom_range(0, 3)),
                                                port));
                3: event_feed.push_back(rand_ev(trcs_pkg::MODE_PACKET));
                4: event_feed.push_back(rand_ev(trcs_pkg::MODE_UNUSED));
                5: port = 16'($urandom);
                default: ;
            endcase
            if (b < blocks)
            begin
                len = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(517, 1023)) : 10'd516;
                event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA,
                                             16'(b), len, port));
            end
            else
            begin
                ending = $urandom_range(0, 11);
                if (ending <= 7)
                begin
                    event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA,
                                                 16'(b), 10'($urandom_range(4, 515)), port));
                end
                else if (ending == 8)
                begin
                    event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_ERROR,
                                                 16'($urandom), 10'($urandom_range(4, 516)),
                                                 port));
                end
                else if (ending == 9)
                begin
                    repeat (int'(regs.max_retries) + 1)
                        event_feed.push_back(make_ev(trcs_pkg::MODE_TIMEOUT, 16'd0, 16'd0,
                                                     10'd0, port));
                end
                else
                begin
                    // abandoned: the next start restarts an active transfer
                    event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA,
                                                 16'(b), 10'd516, port));
                end
            end
        end
    endtask

    task automatic queue_random(int budget);
        while (event_feed.size() < budget)
        begin
            if ($urandom_range(0, 5) == 0)
                event_feed.push_back(rand_ev(2'($urandom_range(1, 3))));
            queue_transfer(($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                                        : int'($urandom_range(1, 8)));
        end
    endtask

    // run sequence
    initial
    begin
        regs.server_address = '0;
        regs.buffer_limit = 32'hFFFF_FFFF;
        regs.callback_mode = 1'b0;
        regs.max_retries = 8'd3;
        seq.phase = trcs_pkg::PH_IDLE;
        seq.expected_block = 16'd1;
        seq.retry_count = '0;
        seq.block_seen = 1'b0;
        seq.server_port = trcs_pkg::SERVER_PORT_INIT;
        seq.byte_total = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: register defaults leave the server address invalid
        send_idle_pct = 30;
        recv_idle_pct = 30;
        event_feed.push_back(make_ev(trcs_pkg::MODE_START, 16'd0, 16'd0, 10'd0, 16'd0));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd1,
                                     10'd516, 16'd7));
        event_feed.push_back(make_ev(trcs_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 10'd0, 16'd0));
        settle();
        set_config(32'h0A00_0001, 32'hFFFF_FFFF, 1'b0, 8'd3);
        event_feed.push_back(make_ev(trcs_pkg::MODE_START, 16'hFFFF, 16'hFFFF, 10'h3FF,
                                     16'hFFFF));
        event_feed.push_back(make_ev(trcs_pkg::MODE_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF,
                                     16'hFFFF));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd1,
                                     10'd3, 16'd1234));
        event_feed.push_back(make_ev(trcs_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 10'd0, 16'd0));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd1,
                                     10'd516, 16'hFFFF));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd1,
                                     10'd516, 16'hFFFF));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, 16'd4, 16'd2, 10'd516,
                                     16'hFFFF));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd2,
                                     10'h3FF, 16'd0));
        repeat (4)
            event_feed.push_back(make_ev(trcs_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 10'd0,
                                         16'd0));
        event_feed.push_back(make_ev(trcs_pkg::MODE_START, 16'd0, 16'd0, 10'd0, 16'd0));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_ERROR, 16'hFFFF,
                                     10'd4, 16'hFFFF));
        event_feed.push_back(make_ev(trcs_pkg::MODE_START, 16'd0, 16'd0, 10'd0, 16'd0));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd1,
                                     10'd4, 16'd69));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd2,
                                     10'd516, 16'd69));
        event_feed.push_back(make_ev(trcs_pkg::MODE_START, 16'd0, 16'd0, 10'd0, 16'd0));
        event_feed.push_back(make_ev(trcs_pkg::MODE_PACKET, trcs_pkg::OP_DATA, 16'd1,
                                     10'd515, 16'd69));
        settle();

        // random phases over a spread of register settings
        set_config($urandom_range(1, 32'hFFFF_FFFF), 32'hFFFF_FFFF, 1'b0, 8'd3);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        queue_random(200);
        settle();

        set_config(32'hFFFF_FFFF, 32'd1, 1'b0, 8'd255);
        send_idle_pct = 50;
        recv_idle_pct = 50;
        queue_random(150);
        settle();

        set_config($urandom_range(1, 32'hFFFF_FFFF), 32'd0, 1'b1, 8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 40;
        queue_random(150);
        settle();

        set_config($urandom_range(1, 32'hFFFF_FFFF), 32'd0, 1'b0, 8'd0);
        queue_random(30);
        settle();

        set_config(32'd0, $urandom, 1'($urandom_range(0, 1)), 8'($urandom));
        queue_random(30);
        settle();

        // zero retries; the long reply hold-off lands in this phase
        set_config($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(600, 5000), 1'b0, 8'd0);
        send_idle_pct = 30;
        recv_idle_pct = 10;
        long_hold_armed = 1'b1;
        queue_random(250);
        settle();

        set_config($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 32'hFFFF_FFFF), 1'b1,
                   8'($urandom_range(2, 254)));
        send_idle_pct = 25;
        recv_idle_pct = 25;
        queue_random(250);
        settle();

        // final stretch without idling
        set_config($urandom_range(1, 32'hFFFF_FFFF), 32'd20_000_000, 1'b0, 8'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(100);
        settle();
        repeat (5) @(posedge clk);

        if (mismatches == 0)
            $display("tb_tftp_read_client_sequencer: clean");
        else
            $display("tb_tftp_read_client_sequencer: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #(10_000_000);
        $display("tb_tftp_read_client_sequencer: errors");
        $finish;
    end

endmodule
